@@ hw/rtl/pcm_frame_to_16bit_converter_defines.svh @@
// Assertion macros shared by the converter.
`ifndef PCM_FRAME_TO_16BIT_CONVERTER_DEFINES_SVH
`define PCM_FRAME_TO_16BIT_CONVERTER_DEFINES_SVH

// Assert that an antecedent implies a consequent in the same cycle.
`define PCM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Assert that an antecedent implies a consequent in the next cycle.
`define PCM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/pcm_pkg.sv @@
`timescale 1ns / 1ps
package pcm_pkg;
   localparam logic [1:0] WIDTH_8  = 2'd0;
   localparam logic [1:0] WIDTH_16 = 2'd1;
   localparam logic [1:0] WIDTH_24 = 2'd2;
   localparam logic [1:0] WIDTH_32 = 2'd3;

   localparam logic [1:0] SEL_MIX   = 2'd0;
   localparam logic [1:0] SEL_LEFT  = 2'd1;
   localparam logic [1:0] SEL_RIGHT = 2'd2;

   localparam logic [1:0] REG_WIDTH  = 2'd0;
   localparam logic [1:0] REG_FLOAT  = 2'd1;
   localparam logic [1:0] REG_STEREO = 2'd2;
   localparam logic [1:0] REG_SEL    = 2'd3;

   localparam logic [31:0] FLOAT_SCALE = 32'h46FFFE00; // 32767.0f

   typedef struct packed {
      logic [1:0] sample_width;
      logic       float_encoding;
      logic       stereo;
      logic [1:0] channel_select;
   } cfg_type;

   // Per-channel intermediate after stage 1: either a finished integer or a
   // decoded float product waiting for rounding.
   typedef struct packed {
      logic              is_float;
      logic signed [15:0] int_val;
      logic              nan;
      logic              sign;
      logic [9:0]        exp;    // biased exponent of the product
      logic [47:0]       mant;   // 24x24 mantissa product
   } chan_type;
endpackage

@@ hw/rtl/pcm_decode.sv @@
`timescale 1ns / 1ps
module pcm_decode (
   input  logic               clock,
   input  logic               enable,
   input  pcm_pkg::cfg_type   cfg,
   input  logic [31:0]        raw,
   output pcm_pkg::chan_type  chan_ff
);
   import pcm_pkg::*;

   chan_type   chan_in;
   logic [23:0] m_a;
   logic [23:0] m_b;

   always_comb begin
      m_a = {|raw[30:23], raw[22:0]};
      m_b = {1'b1, FLOAT_SCALE[22:0]};
      chan_in = '0;
      chan_in.is_float = (cfg.sample_width == WIDTH_32) && cfg.float_encoding;
      chan_in.nan      = (raw[30:23] == 8'hFF) && (raw[22:0] != 23'd0);
      chan_in.sign     = raw[31];
      chan_in.exp      = {2'b00, raw[30:23]} + 10'd14;
      chan_in.mant     = m_a * m_b;
      unique case (cfg.sample_width)
         WIDTH_8:  chan_in.int_val = {{8{~raw[7]}}, ~raw[7], raw[6:0]};
         WIDTH_16: chan_in.int_val = raw[15:0];
         WIDTH_24: chan_in.int_val = raw[23:8];
         default:  chan_in.int_val = raw[31:16];
      endcase
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         chan_ff <= chan_in;
      end
   end
endmodule

@@ hw/rtl/pcm_round.sv @@
`timescale 1ns / 1ps
module pcm_round (
   input  logic                clock,
   input  logic                enable,
   input  pcm_pkg::chan_type   chan,
   output logic signed [15:0]  value_ff
);
   import pcm_pkg::*;

   logic [23:0] pm;
   logic [9:0]  pe;
   logic        rb;
   logic        sticky;
   logic        rnd;
   logic [24:0] rm;
   logic [23:0] fm;
   logic [9:0]  fe;
   logic [15:0] mag;
   logic signed [15:0] value_in;

   // Rounded single product is fm * 2^(fe-127-23); truncation toward zero.
   always_comb begin
      if (chan.mant[47]) begin
         pm = chan.mant[47:24];
         rb = chan.mant[23];
         sticky = |chan.mant[22:0];
         pe = chan.exp + 10'd1;
      end else begin
         pm = chan.mant[46:23];
         rb = chan.mant[22];
         sticky = |chan.mant[21:0];
         pe = chan.exp;
      end
      rnd = rb && (sticky || pm[0]);
      rm = {1'b0, pm} + {24'd0, rnd};
      if (rm[24]) begin
         fm = rm[24:1];
         fe = pe + 10'd1;
      end else begin
         fm = rm[23:0];
         fe = pe;
      end
      // value bits: integer part = fm >> (150 - fe).
      if (fe >= 10'd142) begin
         mag = 16'hFFFF;
      end else if (fe < 10'd127) begin
         mag = 16'd0;
      end else begin
         mag = 16'(fm >> (8'd150 - fe[7:0]));
      end
      if (!chan.is_float) begin
         value_in = chan.int_val;
      end else if (chan.nan) begin
         value_in = '0;
      end else if (chan.sign) begin
         value_in = (mag >= 16'd32768) ? -16'sd32768 : -$signed(mag);
      end else begin
         value_in = (mag >= 16'd32767) ? 16'sd32767 : $signed(mag);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         value_ff <= value_in;
      end
   end
endmodule

@@ hw/rtl/pcm_frame_to_16bit_converter.sv @@
`timescale 1ns / 1ps
// A request beat passes the decode, rounding, mix and output registers to its response beat.
// Throughput: one frame per cycle while the output is not stalled, set by the four-stage pipeline.
// Stages: decode and mantissa multiply, float rounding, channel mix, output.
// Reset: synchronous, active high; clears valid bits and restores the configuration registers.
`include "pcm_frame_to_16bit_converter_defines.svh"
module pcm_frame_to_16bit_converter (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [31:0]        req_left_raw,
   input  logic [31:0]        req_right_raw,
   input  logic               req_last_frame,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_sample,
   output logic               rsp_last_sample,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [3:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   import pcm_pkg::*;

   cfg_type cfg_ff;
   logic    wr;
   logic [1:0] ridx;

   // Configuration registers, written on the access phase of an APB write.
   assign csr_pready = 1'b1;
   assign wr   = csr_psel && csr_penable && csr_pwrite;
   assign ridx = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{sample_width: WIDTH_16, float_encoding: 1'b0,
                     stereo: 1'b0, channel_select: SEL_MIX};
      end else if (wr && csr_paddr[1:0] == 2'b00) begin
         unique case (ridx)
            REG_WIDTH:  cfg_ff.sample_width   <= csr_pwdata[1:0];
            REG_FLOAT:  cfg_ff.float_encoding <= csr_pwdata[0];
            REG_STEREO: cfg_ff.stereo         <= csr_pwdata[0];
            default:    cfg_ff.channel_select <= csr_pwdata[1:0];
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (ridx)
         REG_WIDTH:  csr_prdata[1:0] = cfg_ff.sample_width;
         REG_FLOAT:  csr_prdata[0]   = cfg_ff.float_encoding;
         REG_STEREO: csr_prdata[0]   = cfg_ff.stereo;
         default:    csr_prdata[1:0] = cfg_ff.channel_select;
      endcase
   end

   // The whole pipeline advances together whenever the output beat is free
   // or taken, so a stall freezes every stage and nothing is dropped.
   logic adv;
   logic v1_ff, v2_ff, v3_ff;
   logic l1_ff, l2_ff, l3_ff;
   chan_type c_left, c_right;
   logic signed [15:0] s_left, s_right;
   logic signed [15:0] mix_in, mix_ff;
   logic signed [16:0] sum;

   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   pcm_decode u_dec_l (.clock, .enable(adv), .cfg(cfg_ff), .raw(req_left_raw),
                       .chan_ff(c_left));
   pcm_decode u_dec_r (.clock, .enable(adv), .cfg(cfg_ff), .raw(req_right_raw),
                       .chan_ff(c_right));
   pcm_round u_rnd_l (.clock, .enable(adv), .chan(c_left), .value_ff(s_left));
   pcm_round u_rnd_r (.clock, .enable(adv), .chan(c_right), .value_ff(s_right));

   // Stereo selection; code three falls back to the average like code zero.
   always_comb begin
      sum = 17'(s_left) + 17'(s_right);
      if (!cfg_ff.stereo || cfg_ff.channel_select == SEL_LEFT) begin
         mix_in = s_left;
      end else if (cfg_ff.channel_select == SEL_RIGHT) begin
         mix_in = s_right;
      end else begin
         mix_in = sum[16:1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         rsp_valid <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         rsp_valid <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         l1_ff <= req_last_frame;
         l2_ff <= l1_ff;
         l3_ff <= l2_ff;
         rsp_last_sample <= l3_ff;
         mix_ff <= mix_in;
         rsp_sample <= mix_ff;
      end
   end

   // The mixing stage output register mix_ff follows s_left and s_right; align by stage.
   `PCM_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && !rsp_ready,
                    rsp_valid && $stable(rsp_sample), "response changed while stalled")
   `PCM_ASSERT_IMP(a_ready_free, clock, reset, !rsp_valid, req_ready,
                   "request stalled with empty output")
   `PCM_ASSERT_NEXT(a_flow, clock, reset, adv && v3_ff, rsp_valid,
                    "pipeline beat lost")
endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
   import pcm_pkg::*;

   // One request beat as queued for the driver.
   typedef struct {
      logic [31:0] left_raw;
      logic [31:0] right_raw;
      logic        last_frame;
   } frame_type;

   // One predicted response beat.
   typedef struct {
      logic signed [15:0] sample;
      logic               last_sample;
   } sample_type;

   localparam int LATENCY     = 4;
   localparam int CYCLE_LIMIT = 400000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [31:0]        req_left_raw = '0;
   logic [31:0]        req_right_raw = '0;
   logic               req_last_frame = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [15:0] rsp_sample;
   logic               rsp_last_sample;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [3:0]         csr_paddr = '0;
   logic [31:0]        csr_pwdata = '0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   // The testbench keeps its own copy of the converter configuration. It is
   // updated only while the pipeline is empty, so predictions made at request
   // acceptance always see the setting that the hardware uses.
   cfg_type cfg_copy;

   frame_type  pending_frames[$];
   sample_type expected_samples[$];

   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   bit  hold_sender = 1'b0;
   int  mismatches = 0;
   int  samples_checked = 0;
   int  frames_sent = 0;
   int  cycle_count = 0;
   int  float_frames = 0;
   int  stereo_frames = 0;

   pcm_frame_to_16bit_converter u_top (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // IEEE single float times 32767 in single precision, truncated toward zero
   // and saturated. The exact integer product of the significand and 32767 is
   // rounded to 24 significant bits (nearest, ties to even) as a float multiply
   // would, and then scaled by the exponent.
   function automatic logic signed [15:0] float_to_pcm(input logic [31:0] raw);
      logic [7:0]  ex_bits;
      logic [63:0] prod, q, rem, half, mag, neg;
      int          len, sh, ex;
      ex_bits = raw[30:23];
      if (ex_bits == 8'hFF) begin
         if (raw[22:0] != 0) return 16'sd0;
         return raw[31] ? -16'sd32768 : 16'sd32767;
      end
      prod = {40'd0, (ex_bits == 0) ? 1'b0 : 1'b1, raw[22:0]} * 64'd32767;
      if (prod == 0) return 16'sd0;
      len = 0;
      for (int i = 0; i < 64; i++) begin
         if (prod[i]) len = i + 1;
      end
      sh = (len > 24) ? len - 24 : 0;
      q = prod >> sh;
      if (sh > 0) begin
         rem  = prod & ((64'd1 << sh) - 64'd1);
         half = 64'd1 << (sh - 1);
         if (rem > half || (rem == half && q[0])) q = q + 64'd1;
      end
      ex = sh + ((ex_bits == 0) ? 1 : int'(ex_bits)) - 150;
      if (ex >= 16) mag = 64'd1 << 40;
      else if (ex >= 0) mag = q << ex;
      else if (ex <= -63) mag = 64'd0;
      else mag = q >> (-ex);
      if (!raw[31]) return (mag >= 64'd32767) ? 16'sd32767 : mag[15:0];
      if (mag >= 64'd32768) return -16'sd32768;
      neg = -mag;
      return neg[15:0];
   endfunction

   // Converts one raw channel word under the current width setting.
   function automatic logic signed [15:0] channel_to_pcm(input logic [31:0] raw);
      logic [7:0] flipped;
      case (cfg_copy.sample_width)
         WIDTH_8: begin
            flipped = raw[7:0] ^ 8'h80;
            return {{8{flipped[7]}}, flipped};
         end
         WIDTH_16: return raw[15:0];
         WIDTH_24: return raw[23:8];
         default: begin
            if (cfg_copy.float_encoding) return float_to_pcm(raw);
            return raw[31:16];
         end
      endcase
   endfunction

   // Predicts the response beat for one request frame.
   function automatic sample_type predict_sample(input frame_type f);
      sample_type         s;
      logic signed [15:0] lv, rv;
      logic signed [16:0] sum;
      lv = channel_to_pcm(f.left_raw);
      rv = channel_to_pcm(f.right_raw);
      sum = lv + rv;
      if (!cfg_copy.stereo) s.sample = lv;
      else if (cfg_copy.channel_select == SEL_LEFT) s.sample = lv;
      else if (cfg_copy.channel_select == SEL_RIGHT) s.sample = rv;
      else s.sample = sum[16:1];
      s.last_sample = f.last_frame;
      return s;
   endfunction

   // Driver: at every edge where the current beat was taken (or none was
   // offered), it records the prediction for the taken beat and then decides
   // whether to present the next queued frame or to idle.
   always @(posedge clock) begin
      frame_type f;
      if (!reset && (!req_valid || req_ready)) begin
         if (req_valid) begin
            f.left_raw   = req_left_raw;
            f.right_raw  = req_right_raw;
            f.last_frame = req_last_frame;
            expected_samples.push_back(predict_sample(f));
            frames_sent++;
            if (cfg_copy.sample_width == WIDTH_32 && cfg_copy.float_encoding) float_frames++;
            if (cfg_copy.stereo) stereo_frames++;
         end
         if (pending_frames.size() > 0 && !hold_sender &&
             $urandom_range(99) >= send_idle_pct) begin
            f = pending_frames.pop_front();
            req_valid      <= 1'b1;
            req_left_raw   <= f.left_raw;
            req_right_raw  <= f.right_raw;
            req_last_frame <= f.last_frame;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver back-pressure, redrawn every cycle.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Monitor: every accepted response beat is compared with the oldest
   // prediction, field by field.
   always @(posedge clock) begin
      sample_type exp_s;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_samples.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected beat sample=%0d last=%0b",
                        rsp_sample, rsp_last_sample);
         end else begin
            exp_s = expected_samples.pop_front();
            samples_checked++;
            if (rsp_sample !== exp_s.sample || rsp_last_sample !== exp_s.last_sample) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: beat %0d expected sample=%0d last=%0b, got sample=%0d last=%0b",
                           samples_checked, exp_s.sample, exp_s.last_sample,
                           rsp_sample, rsp_last_sample);
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // A register write on the configuration port: setup cycle, then access.
   task automatic csr_write(input logic [1:0] index, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Waits until every queued frame has been taken and every predicted beat
   // has come back, then lets the pipeline settle.
   task automatic wait_drained();
      while (pending_frames.size() > 0 || req_valid || expected_samples.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   // Writes all four registers; the pipeline must already be drained.
   task automatic configure(input logic [1:0] width, input logic flt,
                            input logic st, input logic [1:0] sel);
      csr_write(REG_WIDTH, {30'd0, width});
      csr_write(REG_FLOAT, {31'd0, flt});
      csr_write(REG_STEREO, {31'd0, st});
      csr_write(REG_SEL, {30'd0, sel});
      cfg_copy.sample_width   = width;
      cfg_copy.float_encoding = flt;
      cfg_copy.stereo         = st;
      cfg_copy.channel_select = sel;
   endtask

   task automatic queue_frame(input logic [31:0] l, input logic [31:0] r, input logic last);
      frame_type f;
      f.left_raw   = l;
      f.right_raw  = r;
      f.last_frame = last;
      pending_frames.push_back(f);
   endtask

   // Raw words: plain random, float corner values, floats around full scale,
   // and small magnitudes in either sign.
   function automatic logic [31:0] random_word();
      logic [31:0] specials[10];
      specials = '{32'h7FC00000, 32'hFFC00001, 32'h7F800000, 32'hFF800000,
                   32'h3F800000, 32'hBF800000, 32'h80000000, 32'h00000001,
                   32'h3F7FFFFF, 32'h3F800001};
      case ($urandom_range(3))
         0: return $urandom;
         1: return specials[$urandom_range(9)];
         2: return {1'($urandom), 8'($urandom_range(110, 145)), 23'($urandom)};
         default: return $urandom_range(1) ? $urandom_range(300) : -$urandom_range(300);
      endcase
   endfunction

   initial begin
      cfg_copy.sample_width   = WIDTH_16;
      cfg_copy.float_encoding = 1'b0;
      cfg_copy.stereo         = 1'b0;
      cfg_copy.channel_select = SEL_MIX;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part. First the reset setting, then each width at its
      // extremes, with ignored bits set.
      queue_frame(32'hFFFF8000, 32'h0, 1'b0);
      queue_frame(32'h00007FFF, 32'hFFFFFFFF, 1'b1);
      wait_drained();
      configure(WIDTH_8, 1'b1, 1'b0, SEL_RIGHT);
      queue_frame(32'hFFFFFF00, 32'h12345678, 1'b0);
      queue_frame(32'h000000FF, 32'h0, 1'b1);
      queue_frame(32'h00000080, 32'h0, 1'b0);
      wait_drained();
      configure(WIDTH_24, 1'b1, 1'b0, SEL_MIX);
      queue_frame(32'hFF800000, 32'h0, 1'b0);
      queue_frame(32'h007FFFFF, 32'h0, 1'b1);
      wait_drained();
      configure(WIDTH_32, 1'b0, 1'b0, SEL_MIX);
      queue_frame(32'h8000FFFF, 32'h0, 1'b0);
      queue_frame(32'h7FFF0000, 32'h0, 1'b1);
      wait_drained();
      // Float samples: NaN, both infinities, full scale, zero, a subnormal.
      configure(WIDTH_32, 1'b1, 1'b0, SEL_MIX);
      queue_frame(32'h7FC00000, 32'h0, 1'b0);
      queue_frame(32'h7F800000, 32'h0, 1'b0);
      queue_frame(32'hFF800000, 32'h0, 1'b0);
      queue_frame(32'h3F800000, 32'h0, 1'b0);
      queue_frame(32'hBF800000, 32'h0, 1'b0);
      queue_frame(32'h80000000, 32'h00000001, 1'b1);
      wait_drained();
      // Stereo: saturation per channel before the average, then each select.
      configure(WIDTH_32, 1'b1, 1'b1, SEL_MIX);
      queue_frame(32'h7F800000, 32'hC0000000, 1'b0);
      queue_frame(32'hBF800000, 32'h3A000000, 1'b1);
      wait_drained();
      configure(WIDTH_16, 1'b0, 1'b1, 2'd3);
      queue_frame(32'h00008000, 32'h00008001, 1'b0);
      queue_frame(32'h00007FFF, 32'h00007FFF, 1'b1);
      wait_drained();
      configure(WIDTH_16, 1'b0, 1'b1, SEL_LEFT);
      queue_frame(32'h00001234, 32'h00008000, 1'b0);
      wait_drained();
      configure(WIDTH_16, 1'b0, 1'b1, SEL_RIGHT);
      queue_frame(32'h00001234, 32'h00008000, 1'b1);
      wait_drained();

      // Random part: 30 blocks of 50 frames, each under a fresh random
      // setting, going through three idling regimes.
      for (int blk = 0; blk < 30; blk++) begin
         if (blk < 10) begin
            send_idle_pct = 33; recv_stall_pct = 72;
         end else if (blk < 20) begin
            send_idle_pct = 72; recv_stall_pct = 33;
         end else begin
            send_idle_pct = 0; recv_stall_pct = 0;
         end
         configure(2'($urandom), 1'($urandom), 1'($urandom), 2'($urandom));
         for (int i = 0; i < 50; i++)
            queue_frame(random_word(), random_word(), ($urandom_range(7) == 0));
         if (blk == 15) begin
            // Hold the sender mid-block until the pipeline runs dry.
            while (pending_frames.size() > 25) @(posedge clock);
            hold_sender = 1'b1;
            while (req_valid || expected_samples.size() > 0) @(posedge clock);
            hold_sender = 1'b0;
         end
         wait_drained();
      end

      $display("Checked %0d samples from %0d frames (%0d float, %0d stereo).",
               samples_checked, frames_sent, float_frames, stereo_frames);
      $display("Covered all widths, float and integer 32-bit, mono and stereo selects.");
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("Mismatches: %0d", mismatches);
         $display("tb: failure");
      end
      $finish;
   end
endmodule
